// File: hw/rtl/fisf_pkg.sv
// Package: single-precision helpers for the reciprocal square root pipeline.
`default_nettype none
package fisf_pkg;

    localparam logic [31:0] RSQ_MAGIC  = 32'h5f375a86;
    localparam logic [31:0] F32_HALF   = 32'h3F000000;
    localparam logic [31:0] F32_THREEH = 32'h3FC00000;
    localparam logic [31:0] F32_QNAN   = 32'h7FC00000;
    localparam logic [7:0]  EXP_MAX    = 8'hFF;

    // aligned operands of a subtract, ready for normalize and round
    typedef struct packed {
        logic        spec;
        logic [31:0] spec_bits;
        logic        sign;
        logic [7:0]  exp;
        logic [27:0] sum;
    } add_t;

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic               za, zb, ia, ib, na, nb, so, g, st, rup;
        logic [47:0]        p;
        logic [23:0]        m;
        logic [24:0]        mr;
        logic signed [10:0] e;
        logic [31:0]        r;
        za = (a[30:23] == 8'd0);
        zb = (b[30:23] == 8'd0);
        ia = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        ib = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        na = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nb = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        so = a[31] ^ b[31];
        p = '0;
        m = '0;
        mr = '0;
        g = 1'b0;
        st = 1'b0;
        rup = 1'b0;
        e = '0;
        if (na || nb || (ia && zb) || (ib && za)) begin
            r = F32_QNAN;
        end else if (ia || ib) begin
            r = {so, EXP_MAX, 23'd0};
        end else if (za || zb) begin
            r = {so, 31'd0};
        end else begin
            p = {1'b1, a[22:0]} * {1'b1, b[22:0]};
            e = $signed({3'b000, a[30:23]}) + $signed({3'b000, b[30:23]}) - 11'sd127;
            if (p[47]) begin
                m = p[47:24];
                g = p[23];
                st = |p[22:0];
                e = e + 11'sd1;
            end else begin
                m = p[46:23];
                g = p[22];
                st = |p[21:0];
            end
            if ((e == 11'sd0) && (&m)) begin
                // rounds up to the smallest normal
                r = {so, 8'd1, 23'd0};
            end else begin
                rup = g && (st || m[0]);
                mr = {1'b0, m} + {24'd0, rup};
                if (mr[24]) begin
                    e = e + 11'sd1;
                    m = mr[24:1];
                end else begin
                    m = mr[23:0];
                end
                if (e >= 11'sd255) begin
                    r = {so, EXP_MAX, 23'd0};
                end else if (e <= 11'sd0) begin
                    r = {so, 31'd0};
                end else begin
                    r = {so, e[7:0], m[22:0]};
                end
            end
        end
        return r;
    endfunction

    // a - b: special cases, operand swap, alignment and significand add or subtract
    function automatic add_t fsub_align(input logic [31:0] a, input logic [31:0] b);
        logic        za, zb, ia, ib, na, nb, sbn, swap;
        logic [7:0]  eb_, es_, d;
        logic [23:0] mbig, msml;
        logic [49:0] wide;
        logic [26:0] sm, bg;
        add_t        r;
        za = (a[30:23] == 8'd0);
        zb = (b[30:23] == 8'd0);
        ia = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        ib = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        na = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        nb = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        sbn = ~b[31];
        r = '0;
        swap = (b[30:0] > a[30:0]);
        eb_ = swap ? b[30:23] : a[30:23];
        es_ = swap ? a[30:23] : b[30:23];
        mbig = swap ? {1'b1, b[22:0]} : {1'b1, a[22:0]};
        msml = swap ? {1'b1, a[22:0]} : {1'b1, b[22:0]};
        d = eb_ - es_;
        wide = {msml, 26'd0} >> d[4:0];
        if (d >= 8'd27) begin
            sm = 27'd1;
        end else begin
            sm = {wide[49:24], |wide[23:0]};
        end
        bg = {mbig, 3'd0};
        if (na || nb || (ia && ib && (a[31] != sbn))) begin
            r.spec = 1'b1;
            r.spec_bits = F32_QNAN;
        end else if (ia) begin
            r.spec = 1'b1;
            r.spec_bits = a;
        end else if (ib) begin
            r.spec = 1'b1;
            r.spec_bits = {sbn, b[30:0]};
        end else if (za && zb) begin
            r.spec = 1'b1;
            r.spec_bits = {a[31] & sbn, 31'd0};
        end else if (za) begin
            r.spec = 1'b1;
            r.spec_bits = {sbn, b[30:0]};
        end else if (zb) begin
            r.spec = 1'b1;
            r.spec_bits = a;
        end else begin
            r.sign = swap ? sbn : a[31];
            r.exp = eb_;
            if (a[31] == sbn) begin
                r.sum = {1'b0, bg} + {1'b0, sm};
            end else begin
                r.sum = {1'b0, bg} - {1'b0, sm};
            end
        end
        return r;
    endfunction

    // normalize, round to nearest-even and pack; special results pass through
    function automatic logic [31:0] fsub_round(input add_t x);
        logic [4:0]         lz;
        logic               found, g, st, rup;
        logic [26:0]        n;
        logic [23:0]        m;
        logic [24:0]        mr;
        logic signed [10:0] e;
        logic [31:0]        r;
        lz = '0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--) begin
            if (!found) begin
                if (x.sum[i]) begin
                    found = 1'b1;
                end else begin
                    lz = lz + 5'd1;
                end
            end
        end
        e = $signed({3'b000, x.exp});
        if (x.sum[27]) begin
            n = {x.sum[27:2], x.sum[1] | x.sum[0]};
            e = e + 11'sd1;
        end else begin
            n = x.sum[26:0] << lz;
            e = e - $signed({6'd0, lz});
        end
        m = n[26:3];
        g = n[2];
        st = |n[1:0];
        rup = g && (st || m[0]);
        mr = {1'b0, m} + {24'd0, rup};
        if (mr[24]) begin
            e = e + 11'sd1;
            m = mr[24:1];
        end else begin
            m = mr[23:0];
        end
        if (x.spec) begin
            r = x.spec_bits;
        end else if (x.sum == 28'd0) begin
            r = 32'd0;
        end else if (e >= 11'sd255) begin
            r = {x.sign, EXP_MAX, 23'd0};
        end else if (e <= 11'sd0) begin
            r = {x.sign, 31'd0};
        end else begin
            r = {x.sign, e[7:0], m[22:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fast_inverse_sqrt_float_top.sv
// Top level: pipelined fast reciprocal square root with one Newton step.
//
// channel | dir | tdata fields (low bit up)
// s_      | in  | x_bits[31:0]
// m_      | out | y_bits[31:0]
//
// Six register stages, one request per cycle while the output is not stalled.
// Stages: x*0.5 and guess, hx*y, t*y, 1.5-t align, normalize/round, y*s.
// Synchronous active-low reset clears the stage valid bits.
// A stalled output holds the whole pipe; nothing is dropped or repeated.
`default_nettype none
module fast_inverse_sqrt_float_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // x_bits[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // y_bits[31:0]
);

    logic [5:0]  vld_reg, vld_next;
    logic        adv;
    logic [31:0] hx_reg, t1_reg, t2_reg, s_reg, y_reg;
    logic [31:0] g1_reg, g2_reg, g3_reg, g4_reg, g5_reg;
    fisf_pkg::add_t al_reg;

    assign adv      = !vld_reg[5] || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[4:0], s_tvalid};
    assign m_tvalid = vld_reg[5];
    assign m_tdata  = y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hx_reg <= fisf_pkg::fmul(s_tdata, fisf_pkg::F32_HALF);
            g1_reg <= fisf_pkg::RSQ_MAGIC - {1'b0, s_tdata[31:1]};
            t1_reg <= fisf_pkg::fmul(hx_reg, g1_reg);
            g2_reg <= g1_reg;
            t2_reg <= fisf_pkg::fmul(t1_reg, g2_reg);
            g3_reg <= g2_reg;
            al_reg <= fisf_pkg::fsub_align(fisf_pkg::F32_THREEH, t2_reg);
            g4_reg <= g3_reg;
            s_reg  <= fisf_pkg::fsub_round(al_reg);
            g5_reg <= g4_reg;
            y_reg  <= fisf_pkg::fmul(g5_reg, s_reg);
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/fisf_checker.sv
// Checker: port-level assertions for the reciprocal square root top level.
`default_nettype none
module fisf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken during output stall");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");

    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("unknown bits in accepted request");

endmodule

bind fast_inverse_sqrt_float_top fisf_checker u_fisf_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

// File: tb/tb_fast_inverse_sqrt_float_top.sv
// Testbench for the reciprocal square root pipeline against a bit-exact predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_fast_inverse_sqrt_float_top;

    localparam logic [31:0] SGN_BIT = 32'h80000000;
    localparam logic [31:0] POS_INF = 32'h7F800000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // x_bits[31:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // y_bits[31:0]

    logic [31:0] rsqrt_expected[$];
    int          err_cnt;
    int          burst_left;
    int          ready_cyc;
    int          ready_mode;

    fast_inverse_sqrt_float_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // single bits to real, subnormal operands read as zero
    function automatic real sp_to_real(input logic [31:0] b);
        logic [63:0] d;
        if (b[30:23] == 8'd0) begin
            d = {b[31], 63'd0};
        end else if (b[30:23] == 8'hFF) begin
            d = {b[31], 11'h7FF, b[22:0], 29'd0};
        end else begin
            d = {b[31], 3'd0 + 11'd896 + {3'd0, b[30:23]}, b[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // real to single bits, round to nearest-even, flush subnormal results
    function automatic logic [31:0] real_to_sp(input real v);
        logic [63:0] d;
        logic        s, g, st, rup;
        logic [23:0] m;
        logic [24:0] mr;
        int          e;
        d = $realtobits(v);
        s = d[63];
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 52'd0) ? fisf_pkg::F32_QNAN : ({s, 31'd0} | POS_INF);
        end
        if (d[62:52] == 11'd0) begin
            return {s, 31'd0};
        end
        e = int'(d[62:52]) - 896;
        if (e == 0) begin
            rup = d[29] && ((|d[28:0]) || d[30]);
            if ((&d[51:30]) && rup) begin
                return {s, 8'd1, 23'd0};
            end
            return {s, 31'd0};
        end
        if (e < 0) begin
            return {s, 31'd0};
        end
        m = {1'b1, d[51:29]};
        g = d[28];
        st = |d[27:0];
        rup = g && (st || m[0]);
        mr = {1'b0, m} + {24'd0, rup};
        if (mr[24]) begin
            e = e + 1;
            m = mr[24:1];
        end else begin
            m = mr[23:0];
        end
        if (e >= 255) begin
            return {s, 31'd0} | POS_INF;
        end
        return {s, e[7:0], m[22:0]};
    endfunction

    function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
        return real_to_sp(sp_to_real(a) * sp_to_real(b));
    endfunction

    function automatic logic [31:0] rsqrt_predict(input logic [31:0] x);
        logic [31:0] hx, y, t, sc;
        hx = sp_mul(x, fisf_pkg::F32_HALF);
        y = fisf_pkg::RSQ_MAGIC - (x >> 1);
        t = sp_mul(hx, y);
        t = sp_mul(t, y);
        sc = real_to_sp(sp_to_real(fisf_pkg::F32_THREEH) - sp_to_real(t));
        return sp_mul(y, sc);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        err_cnt++;
    endtask

    // one request; bursts of random length separated by random gaps
    task automatic send_x(input logic [31:0] x);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        rsqrt_expected.push_back(rsqrt_predict(x));
    endtask

    task automatic idle_tx();
        s_tvalid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (rsqrt_expected.size() == 0) begin
                report_mismatch("unexpected y_bits", m_tdata, 32'd0);
            end else begin
                if (m_tdata !== rsqrt_expected[0]) begin
                    report_mismatch("y_bits", m_tdata, rsqrt_expected[0]);
                end
                void'(rsqrt_expected.pop_front());
            end
        end
    end

    // receiver stall pattern: the mode is redrawn at random from a free-running cycle counter
    always @(posedge aclk) begin
        ready_cyc <= ready_cyc + 1;
        if (ready_cyc % 64 == 0) begin
            ready_mode <= $urandom_range(0, 3);
        end
        case (ready_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_tready <= (ready_cyc % 5) < 2;
            end
            default: begin
                m_tready <= $urandom_range(0, 7) != 0;
            end
        endcase
    end

    task automatic test_zero_and_sign();
        send_x(32'h00000000);
        send_x(SGN_BIT);
        send_x(32'h3F800000);
        send_x(32'hBF800000);
        send_x(32'h40800000);
        send_x(32'hFFFFFFFF);
    endtask

    task automatic test_specials();
        send_x(POS_INF);
        send_x(32'hFF800000);
        send_x(32'h7FC00000);
        send_x(32'h7F800001);
        send_x(32'hFFC00000);
        send_x(32'h7F7FFFFF);
        send_x(32'hFF7FFFFF);
    endtask

    task automatic test_subnormals();
        send_x(32'h00000001);
        send_x(32'h007FFFFF);
        send_x(32'h80400000);
        send_x(32'h00800000);
        send_x(32'h00800001);
        send_x(32'h01000000);
    endtask

    task automatic test_ranges();
        send_x(32'h3E800000);
        send_x(32'h4B000000);
        send_x(32'h5F000000);
        send_x(32'h20000000);
        send_x(32'h40490FDB);
    endtask

    task automatic test_random(input int n);
        logic [31:0] x;
        int          k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 9);
            x = $urandom;
            if (k < 5) begin
                x[31] = 1'b0;
                x[30:23] = 8'($urandom_range(1, 254));
            end else if (k == 5) begin
                x[30:23] = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'hFF;
                if ($urandom_range(0, 1) == 0) x[22:0] = 23'd0;
            end else if (k == 6) begin
                x[30:23] = 8'($urandom_range(0, 3));
            end else if (k == 7) begin
                x[30:23] = 8'($urandom_range(251, 255));
            end
            send_x(x);
        end
        idle_tx();
    endtask

    initial begin
        err_cnt    = 0;
        burst_left = 0;
        ready_cyc  = 0;
        ready_mode = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 32'd0;
        m_tready = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_zero_and_sign();
        test_specials();
        test_subnormals();
        test_ranges();
        test_random(1850);
        while (rsqrt_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire
